// File: sv/b64e_pkg.sv
package b64e_pkg;

    // one input beat: a raw byte and the end-of-message mark
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_beat;

    // one output beat: an ASCII character and the end-of-message mark
    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
    } t_out_beat;

    // number of characters produced for a complete three-byte group
    localparam int unsigned GROUP_CHARS = 4;
    localparam int unsigned LEFT_W      = $clog2(GROUP_CHARS + 1);
    localparam int unsigned SEXTET_W    = 6;
    localparam int unsigned SHIFT_W     = GROUP_CHARS * SEXTET_W;

    // map a 6-bit code to its standard base64 character
    function automatic logic [7:0] b64_char(input logic [5:0] code);
        logic [7:0] c;
        c = {2'b00, code};
        case (code) inside
            [6'd0:6'd25]:  b64_char = 8'h41 + c;
            [6'd26:6'd51]: b64_char = 8'h61 + c - 8'd26;
            [6'd52:6'd61]: b64_char = 8'h30 + c - 8'd52;
            6'd62:         b64_char = 8'h2B;
            default:       b64_char = 8'h2F;
        endcase
    endfunction

endpackage

// File: sv/base64_encoder_unpadded.sv
// Unpadded base64 encoder, standard alphabet.
// Input channel: one byte per beat on i_in_beat, in_last marks the final
// byte of a message. Output channel: one ASCII character per beat on
// o_out_beat, out_last marks the final character of the message.
// Bytes that do not complete a group (and are not last) are only stored and
// are taken every cycle. A byte that completes a group of three, or a last
// byte, loads 4, 3 or 2 sextets into the output shifter; the first character
// is offered the cycle after that byte is taken, then one per unstalled cycle.
// The output shifter is the single result register: a byte that makes
// characters is taken when the shifter is empty or its final character is
// leaving in the same cycle, so steady-state throughput is set by the
// one-character output channel.
// When the receiver stalls, the current character holds and any byte that
// would load new characters is stalled; storing bytes still proceeds.
// Reset clears the pending bytes and empties the output shifter; no characters
// are lost or invented across a stall.
module base64_encoder_unpadded (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  b64e_pkg::t_in_beat i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output b64e_pkg::t_out_beat o_out_beat
);
    import b64e_pkg::*;

    logic [15:0]         r_held;
    logic [1:0]          r_held_cnt;
    logic [SHIFT_W-1:0]  r_shift;
    logic [LEFT_W-1:0]   r_left;
    logic                r_last;

    logic [15:0]         n_held;
    logic [1:0]          n_held_cnt;
    logic [SHIFT_W-1:0]  n_shift;
    logic [LEFT_W-1:0]   n_left;
    logic                n_last;

    logic                in_take;
    logic                out_take;
    logic                produces;
    logic                shift_free;
    logic                two_held;
    logic [7:0]          b0;
    logic [7:0]          b1;
    logic [7:0]          byte_in;

    assign byte_in  = i_in_beat.in_byte;
    assign b0       = r_held[15:8];
    assign b1       = r_held[7:0];
    // a count of three is handled as two
    assign two_held = r_held_cnt[1];
    assign produces = i_in_beat.in_last | two_held;

    // handshake
    assign o_out_valid = (r_left != '0);
    assign out_take    = o_out_valid & ~i_out_stall;
    assign shift_free  = (r_left == '0) | ((r_left == LEFT_W'(1)) & ~i_out_stall);
    assign o_in_stall  = produces & ~shift_free;
    assign in_take     = i_in_valid & ~o_in_stall;

    // output beat from the top sextet
    assign o_out_beat.out_char = b64_char(r_shift[SHIFT_W-1 -: SEXTET_W]);
    assign o_out_beat.out_last = r_last & (r_left == LEFT_W'(1));

    // next pending bytes and shifter contents
    always_comb begin
        n_held     = r_held;
        n_held_cnt = r_held_cnt;
        n_shift    = r_shift;
        n_left     = r_left;
        n_last     = r_last;
        if (out_take) begin
            n_shift = {r_shift[SHIFT_W-SEXTET_W-1:0], {SEXTET_W{1'b0}}};
            n_left  = r_left - LEFT_W'(1);
        end
        if (in_take) begin
            if (two_held) begin
                n_shift    = {b0[7:2], b0[1:0], b1[7:4], b1[3:0], byte_in[7:6],
                              byte_in[5:0]};
                n_left     = LEFT_W'(4);
                n_last     = i_in_beat.in_last;
                n_held     = '0;
                n_held_cnt = '0;
            end else if (r_held_cnt == 2'd1) begin
                if (i_in_beat.in_last) begin
                    n_shift    = {b0[7:2], b0[1:0], byte_in[7:4], byte_in[3:0], 2'b00,
                                  {SEXTET_W{1'b0}}};
                    n_left     = LEFT_W'(3);
                    n_last     = 1'b1;
                    n_held     = '0;
                    n_held_cnt = '0;
                end else begin
                    n_held     = {b0, byte_in};
                    n_held_cnt = 2'd2;
                end
            end else begin
                if (i_in_beat.in_last) begin
                    n_shift    = {byte_in[7:2], byte_in[1:0], 4'b0000,
                                  {(2*SEXTET_W){1'b0}}};
                    n_left     = LEFT_W'(2);
                    n_last     = 1'b1;
                    n_held     = '0;
                    n_held_cnt = '0;
                end else begin
                    n_held     = {byte_in, 8'h00};
                    n_held_cnt = 2'd1;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= '0;
            r_held_cnt <= '0;
            r_left     <= '0;
            r_last     <= 1'b0;
        end else begin
            r_held     <= n_held;
            r_held_cnt <= n_held_cnt;
            r_left     <= n_left;
            r_last     <= n_last;
        end
    end

    // sextet shifter payload
    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
    end

    // pending count never reaches three
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_cnt != 2'd3)
        else $error("pending byte count out of range");

    // shifter never holds more than a full group
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= LEFT_W'(GROUP_CHARS))
        else $error("output shifter count out of range");

    // a byte that makes characters shows a character on the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && produces) |=> (o_out_valid && r_left >= LEFT_W'(2)))
        else $error("group taken but no characters loaded");

    // a byte that is only stored loads nothing
    a_store_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && !produces && !o_out_valid) |=> !o_out_valid)
        else $error("stored byte produced output");

endmodule
